@@ sv/dwbl_pkg.sv @@
package dwbl_pkg;

  // field widths of the request, result and configuration channels
  localparam int NOW_W   = 48;
  localparam int SIDX_W  = 4;
  localparam int SIDX_N  = 1 << SIDX_W;
  localparam int REQ_W   = 32;
  localparam int BYTES_W = 40;
  localparam int USEC_W  = 26;
  localparam int WMS_W   = 16;
  localparam int CIDX_W  = 1;

  // default sizing of the block
  localparam int NUM_SENSORS_DEF = 16;
  localparam int TIME_BITS_DEF   = 48;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_GLOBAL_LIMIT = 1'b0;
  localparam logic [CIDX_W-1:0] CFG_WINDOW_MS    = 1'b1;

  // request function codes
  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_CLEAR   = 1'b1;

  // window length conversion and reset value, and byte count saturation value
  localparam logic [USEC_W-1:0]  US_PER_MS       = 26'd1000;
  localparam logic [USEC_W-1:0]  WINDOW_US_RESET = 26'd100000;
  localparam logic [BYTES_W-1:0] BYTES_MAX       = {BYTES_W{1'b1}};

endpackage

@@ sv/dwbl_if.sv @@
// request channel
interface dwbl_req_if
  import dwbl_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               func;
  logic [NOW_W-1:0]   now_us;
  logic [SIDX_W-1:0]  sensor_index;
  logic [REQ_W-1:0]   request_bytes;
  logic [BYTES_W-1:0] slot_cap_bytes;

  modport source (
    output valid, func, now_us, sensor_index, request_bytes, slot_cap_bytes,
    input  ready
  );
  modport sink (
    input  valid, func, now_us, sensor_index, request_bytes, slot_cap_bytes,
    output ready
  );
endinterface

// result channel
interface dwbl_rsp_if
  import dwbl_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [USEC_W-1:0]  wait_time;
  logic               granted;
  logic [BYTES_W-1:0] global_bytes_now;
  logic [BYTES_W-1:0] sensor_bytes_now;

  modport source (
    output valid, wait_time, granted, global_bytes_now, sensor_bytes_now,
    input  ready
  );
  modport sink (
    input  valid, wait_time, granted, global_bytes_now, sensor_bytes_now,
    output ready
  );
endinterface

// configuration write channel
interface dwbl_cfg_if
  import dwbl_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [BYTES_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ sv/dual_window_bandwidth_limiter.sv @@
// Fixed-window byte budget limiter: one global window plus one window per sensor slot, all of
// one common window length. A request (func 0) restarts any window that has fully elapsed,
// opens an unseen slot at now_us, and is granted with delay 0 when the bytes fit both the
// global and the slot budget (slot limit 0 means no slot limit); otherwise it is refused with
// the largest remaining time of the exhausted windows, at least 1 us. A clear (func 1) empties
// all windows and restarts the global one at now_us, returning an all-zero result. Time wraps
// modulo 2^TIME_BITS. A request's result is loaded into the output register after its transfer
// passes through table read, then window evaluation, then budget check and write-back, and
// a new request is taken only after the previous one has written back, so one request is in
// flight at a time; this follows from the read-modify-write of the slot table through its
// registered-read RAM. The result sits in an output register, so a held result does not block
// the next request until that next request reaches its write-back. Slot table contents are
// left as they come out of reset; a valid flag per slot covers unseen slots, so no clearing
// pass is needed.
module dual_window_bandwidth_limiter
  import dwbl_pkg::*;
#(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  dwbl_req_if.sink   req,
  dwbl_rsp_if.source rsp,
  dwbl_cfg_if.sink   cfg
);

  localparam int SLOT_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int ENT_W  = TIME_BITS + BYTES_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_EVAL   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] start;
    logic [BYTES_W-1:0]   used;
  } entry_t;

  state_t state;
  state_t state_next;

  // configuration
  logic [BYTES_W-1:0] glob_cap;
  logic [USEC_W-1:0]  win_len_us;

  // global window
  logic [TIME_BITS-1:0] g_start;
  logic [BYTES_W-1:0]   g_used;

  // slot valid flags
  logic [NUM_SENSORS-1:0] slot_valid;

  // captured request
  logic                 func_r;
  logic [TIME_BITS-1:0] now_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [REQ_W-1:0]     bytes_r;
  logic [BYTES_W-1:0]   slimit_r;

  // evaluated windows
  logic [TIME_BITS-1:0] g_start_e;
  logic [BYTES_W-1:0]   g_used_e;
  logic [USEC_W-1:0]    g_rem;
  logic [TIME_BITS-1:0] s_start_e;
  logic [BYTES_W-1:0]   s_used_e;
  logic [USEC_W-1:0]    s_rem;

  // output register
  logic               out_valid;
  logic [USEC_W-1:0]  out_delay;
  logic               out_granted;
  logic [BYTES_W-1:0] out_g_bytes;
  logic [BYTES_W-1:0] out_s_bytes;

  logic              req_xfer;
  logic              commit;
  logic [SLOT_W-1:0] slot_lut [SIDX_N];
  logic [SLOT_W-1:0] slot_in;
  entry_t            rd_ent;
  entry_t            wr_ent;
  logic [ENT_W-1:0]  rd_data;

  // sensor index folded onto the slot count
  for (genvar g = 0; g < SIDX_N; g++) begin : g_slot_lut
    assign slot_lut[g] = SLOT_W'(g % NUM_SENSORS);
  end
  assign slot_in = slot_lut[req.sensor_index];

  assign req.ready = (state == ST_IDLE) && !rst;
  assign cfg.ready = !rst;
  assign req_xfer  = req.valid && req.ready;
  assign commit    = (state == ST_COMMIT) && (!out_valid || rsp.ready);

  // state sequencing
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_xfer) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      glob_cap   <= '0;
      win_len_us <= WINDOW_US_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_GLOBAL_LIMIT: glob_cap   <= cfg.data;
        CFG_WINDOW_MS:    win_len_us <= USEC_W'(cfg.data[WMS_W-1:0]) * US_PER_MS;
        default:          ;
      endcase
    end
  end

  // capture request on transfer
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      func_r   <= req.func;
      now_r    <= TIME_BITS'(req.now_us);
      slot_r   <= slot_in;
      bytes_r  <= req.request_bytes;
      slimit_r <= req.slot_cap_bytes;
    end
  end

  // slot table
  dwbl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SENSORS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (commit && (func_r == FUNC_REQUEST)),
    .waddr (slot_r),
    .wdata (wr_ent),
    .re    (req_xfer),
    .raddr (slot_in),
    .rdata (rd_data)
  );
  assign rd_ent = entry_t'(rd_data);

  // window restart and remaining time
  logic [TIME_BITS-1:0] g_elapsed;
  logic                 g_restart;
  logic [TIME_BITS-1:0] s_start_raw;
  logic [BYTES_W-1:0]   s_used_raw;
  logic [TIME_BITS-1:0] s_elapsed;
  logic                 s_restart;

  always_comb begin
    g_elapsed   = now_r - g_start;
    g_restart   = g_elapsed >= TIME_BITS'(win_len_us);
    s_start_raw = slot_valid[slot_r] ? rd_ent.start : now_r;
    s_used_raw  = slot_valid[slot_r] ? rd_ent.used  : '0;
    s_elapsed   = now_r - s_start_raw;
    s_restart   = s_elapsed >= TIME_BITS'(win_len_us);
  end

  always_ff @(posedge clk) begin
    if (state == ST_EVAL) begin
      g_start_e <= g_restart ? now_r : g_start;
      g_used_e  <= g_restart ? '0 : g_used;
      g_rem     <= g_restart ? win_len_us : win_len_us - g_elapsed[USEC_W-1:0];
      s_start_e <= s_restart ? now_r : s_start_raw;
      s_used_e  <= s_restart ? '0 : s_used_raw;
      s_rem     <= s_restart ? win_len_us : win_len_us - s_elapsed[USEC_W-1:0];
    end
  end

  // budget check
  logic [BYTES_W:0]   g_sum;
  logic [BYTES_W:0]   s_sum;
  logic               g_ex;
  logic               s_ex;
  logic               grant;
  logic [USEC_W-1:0]  pick;
  logic [USEC_W-1:0]  delay;
  logic [BYTES_W-1:0] g_used_new;
  logic [BYTES_W-1:0] s_used_new;

  always_comb begin
    g_sum = {1'b0, g_used_e} + (BYTES_W + 1)'(bytes_r);
    s_sum = {1'b0, s_used_e} + (BYTES_W + 1)'(bytes_r);
    g_ex  = g_sum > {1'b0, glob_cap};
    s_ex  = (slimit_r != '0) && (s_sum > {1'b0, slimit_r});
    grant = !g_ex && !s_ex;
    if (g_ex && s_ex) begin
      pick = (g_rem >= s_rem) ? g_rem : s_rem;
    end else if (g_ex) begin
      pick = g_rem;
    end else begin
      pick = s_rem;
    end
    if (grant) begin
      delay = '0;
    end else if (pick == '0) begin
      delay = USEC_W'(1);
    end else begin
      delay = pick;
    end
    g_used_new = grant ? g_sum[BYTES_W-1:0] : g_used_e;
    if (!grant) begin
      s_used_new = s_used_e;
    end else if (s_sum[BYTES_W]) begin
      s_used_new = BYTES_MAX;
    end else begin
      s_used_new = s_sum[BYTES_W-1:0];
    end
    wr_ent.start = s_start_e;
    wr_ent.used  = s_used_new;
  end

  // global window and slot flags update
  always_ff @(posedge clk) begin
    if (rst) begin
      g_start    <= '0;
      g_used     <= '0;
      slot_valid <= '0;
    end else if (commit) begin
      if (func_r == FUNC_CLEAR) begin
        g_start    <= now_r;
        g_used     <= '0;
        slot_valid <= '0;
      end else begin
        g_start            <= g_start_e;
        g_used             <= g_used_new;
        slot_valid[slot_r] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (func_r == FUNC_CLEAR) begin
        out_delay   <= '0;
        out_granted <= 1'b0;
        out_g_bytes <= '0;
        out_s_bytes <= '0;
      end else begin
        out_delay   <= delay;
        out_granted <= grant;
        out_g_bytes <= g_used_new;
        out_s_bytes <= s_used_new;
      end
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.wait_time        = out_delay;
  assign rsp.granted          = out_granted;
  assign rsp.global_bytes_now = out_g_bytes;
  assign rsp.sensor_bytes_now = out_s_bytes;

endmodule

@@ sv/dwbl_ram.sv @@
module dwbl_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/dwbl_checker.sv @@
module dwbl_checker
  import dwbl_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [USEC_W-1:0]  rsp_wait_time,
  input logic               rsp_granted,
  input logic [BYTES_W-1:0] rsp_global_bytes_now,
  input logic [BYTES_W-1:0] rsp_sensor_bytes_now
);

  // a held result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before transfer");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in flight");

  // a new result follows a request transfer that went through evaluation and commit unstalled
  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
    else $error("result without matching request");

  // grants carry no delay
  a_grant_delay: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_granted |-> rsp_wait_time == '0)
    else $error("granted result with nonzero delay");

  // only a clear returns a refusal with zero delay, and it empties all counts
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_granted && rsp_wait_time == '0 |->
      rsp_global_bytes_now == '0 && rsp_sensor_bytes_now == '0)
    else $error("zero-delay refusal with nonzero counts");

endmodule

bind dual_window_bandwidth_limiter dwbl_checker u_dwbl_checker (
  .clk                  (clk),
  .rst                  (rst),
  .req_valid            (req.valid),
  .req_ready            (req.ready),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .rsp_wait_time        (rsp.wait_time),
  .rsp_granted          (rsp.granted),
  .rsp_global_bytes_now (rsp.global_bytes_now),
  .rsp_sensor_bytes_now (rsp.sensor_bytes_now)
);
